### hdl/rolling_average_defines.svh
// Assertion macros shared by the rolling average RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ROLLING_AVERAGE_DEFINES_SVH
`define ROLLING_AVERAGE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// ante holds, cons holds in the same cycle
`define RA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rolling_average: check failed");

// ante holds, cons holds in the next cycle
`define RA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rolling_average: check failed");

`else

`define RA_ASSERT_IMPL(name, ante, cons)
`define RA_ASSERT_NEXT(name, ante, cons)

`endif

`endif

### hdl/ra_pkg.sv
package ra_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 23;
  localparam int CNT_W     = 7;
  localparam int AVG_W     = 24;
  localparam int FRAC_W    = 8;
  // magnitude of sum times 256 stays below 2**30
  localparam int DVD_W     = 30;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = DVD_W / DIV_BITS;
  localparam int STEP_W    = 4;

  // queue depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CNT_W-1:0] WINDOW_RESET = 7'd8;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_UPD
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } back_state_t;

endpackage

### hdl/ra_fifo.sv
module ra_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ra_pkg::job_t  job_in,
  output logic          full,
  input  logic          pop,
  output ra_pkg::job_t  job_out,
  output logic          empty
);

  ra_pkg::job_t                  q_r [ra_pkg::QUEUE_DEPTH];
  logic [ra_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ra_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ra_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign full    = (cnt_r == ra_pkg::QCNT_W'(ra_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign job_out = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

### hdl/ra_front.sv
`include "rolling_average_defines.svh"

module ra_front #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write,
  input  logic [ra_pkg::CNT_W-1:0]          cfg_window_size,
  input  logic                              in_push,
  input  logic signed [ra_pkg::SAMPLE_W-1:0] in_sample,
  output logic                              in_full,
  output logic                              q_push,
  output ra_pkg::job_t                      q_job,
  input  logic                              q_full
);

  localparam int CW       = ra_pkg::CNT_W;
  localparam int SW       = ra_pkg::SUM_W;
  localparam int AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IW       = (AW > CW) ? AW : CW;
  localparam int SIZE_CAP = (MAX_WINDOW > (1 << CW) - 1) ? (1 << CW) - 1 : MAX_WINDOW;
  localparam logic [CW-1:0] CAP = CW'(SIZE_CAP);

  logic signed [ra_pkg::SAMPLE_W-1:0] mem [MAX_WINDOW];

  ra_pkg::front_state_t               state_r, state_nxt;
  logic [CW-1:0]                      ws_r;
  logic [CW-1:0]                      fill_r, fill_nxt;
  logic [CW-1:0]                      wp_r, wp_nxt;
  logic signed [SW-1:0]               sum_r, sum_nxt;
  logic signed [ra_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [ra_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [CW-1:0]                      eff_size;
  logic                               filling, accept;
  logic [IW-1:0]                      fill_wide, wp_wide;
  logic [AW-1:0]                      fill_addr, wp_addr;
  logic                               mem_we;
  logic [AW-1:0]                      mem_wa;
  logic signed [ra_pkg::SAMPLE_W-1:0] mem_wd;

  // zero acts as one, oversize clamps to the store depth
  always_comb begin
    if (ws_r == '0) begin
      eff_size = CW'(1);
    end else if (ws_r > CAP) begin
      eff_size = CAP;
    end else begin
      eff_size = ws_r;
    end
  end

  assign fill_wide = IW'(fill_r);
  assign wp_wide   = IW'(wp_r);
  assign fill_addr = fill_wide[AW-1:0];
  assign wp_addr   = wp_wide[AW-1:0];
  assign filling   = (fill_r < eff_size);
  assign in_full   = (state_r != ra_pkg::F_IDLE) || q_full;
  assign accept    = in_push && !in_full;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    wp_nxt    = wp_r;
    sum_nxt   = sum_r;
    mem_we    = 1'b0;
    mem_wa    = fill_addr;
    mem_wd    = in_sample;
    q_push    = 1'b0;
    unique case (state_r)
      ra_pkg::F_IDLE: begin
        if (accept) begin
          if (filling) begin
            // append at the next free slot
            mem_we   = 1'b1;
            sum_nxt  = sum_r + SW'(in_sample);
            fill_nxt = fill_r + 1'b1;
            q_push   = 1'b1;
          end else begin
            // go to F_UPD, which uses the oldest entry read from the store
            state_nxt = ra_pkg::F_UPD;
          end
        end
      end
      ra_pkg::F_UPD: begin
        mem_we    = 1'b1;
        mem_wa    = wp_addr;
        mem_wd    = sample_r;
        sum_nxt   = sum_r + SW'(sample_r) - SW'(rd_data_r);
        wp_nxt    = (wp_r + 1'b1 == eff_size) ? '0 : wp_r + 1'b1;
        q_push    = 1'b1;
        state_nxt = ra_pkg::F_IDLE;
      end
      default: begin
        state_nxt = ra_pkg::F_IDLE;
      end
    endcase
  end

  assign q_job.sum   = sum_nxt;
  assign q_job.count = fill_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ra_pkg::F_IDLE;
      ws_r    <= ra_pkg::WINDOW_RESET;
      fill_r  <= '0;
      wp_r    <= '0;
      sum_r   <= '0;
    end else if (cfg_write) begin
      // drop the whole window
      state_r <= ra_pkg::F_IDLE;
      ws_r    <= cfg_window_size;
      fill_r  <= '0;
      wp_r    <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      wp_r    <= wp_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[wp_addr];
  end

  `RA_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= eff_size)
  `RA_ASSERT_NEXT(a_full_to_upd, accept && !filling && !cfg_write, state_r == ra_pkg::F_UPD)

endmodule

### hdl/ra_back.sv
`include "rolling_average_defines.svh"

module ra_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  ra_pkg::job_t                     q_job,
  output logic                             q_pop,
  input  logic                             out_pop,
  output logic                             out_empty,
  output logic signed [ra_pkg::AVG_W-1:0]  out_average,
  output logic [ra_pkg::CNT_W-1:0]         out_samples_held
);

  localparam int CW = ra_pkg::CNT_W;
  localparam int DW = ra_pkg::DVD_W;
  localparam int AV = ra_pkg::AVG_W;
  localparam int SW = ra_pkg::SUM_W;

  ra_pkg::back_state_t         state_r, state_nxt;
  logic [DW-1:0]               dvd_r, dvd_nxt;
  logic [CW-1:0]               rem_r, rem_nxt;
  logic [CW-1:0]               div_r, div_nxt;
  logic                        neg_r, neg_nxt;
  logic [ra_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [AV-1:0]        avg_r, avg_nxt;
  logic [CW-1:0]               held_r, held_nxt;
  logic [SW-1:0]               mag;
  logic [DW-1:0]               step_dvd;
  logic [CW-1:0]               step_rem;
  logic [CW:0]                 trial;
  logic [AV-1:0]               quot;

  // two restoring-division bits per cycle
  always_comb begin
    step_rem = rem_r;
    step_dvd = dvd_r;
    trial    = '0;
    for (int i = 0; i < ra_pkg::DIV_BITS; i++) begin
      trial    = {step_rem, step_dvd[DW-1]};
      step_dvd = {step_dvd[DW-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        step_rem    = CW'(trial - {1'b0, div_r});
        step_dvd[0] = 1'b1;
      end else begin
        step_rem = trial[CW-1:0];
      end
    end
  end

  assign mag  = q_job.sum[SW-1] ? SW'(-q_job.sum) : SW'(q_job.sum);
  assign quot = dvd_r[AV-1:0];

  always_comb begin
    state_nxt     = state_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    avg_nxt       = avg_r;
    held_nxt      = held_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    unique case (state_r)
      ra_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          neg_nxt   = q_job.sum[SW-1];
          dvd_nxt   = DW'({mag, ra_pkg::FRAC_W'(0)});
          rem_nxt   = '0;
          div_nxt   = q_job.count;
          step_nxt  = '0;
          state_nxt = ra_pkg::B_RUN;
        end
      end
      ra_pkg::B_RUN: begin
        dvd_nxt  = step_dvd;
        rem_nxt  = step_rem;
        step_nxt = step_r + 1'b1;
        if (step_r == ra_pkg::STEP_W'(ra_pkg::DIV_STEPS - 1)) begin
          state_nxt = ra_pkg::B_DONE;
        end
      end
      ra_pkg::B_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_pop) begin
          avg_nxt       = neg_r ? AV'(-quot) : AV'(quot);
          held_nxt      = div_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ra_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = ra_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ra_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    avg_r  <= avg_nxt;
    held_r <= held_nxt;
  end

  assign out_empty        = !out_valid_r;
  assign out_average      = avg_r;
  assign out_samples_held = held_r;

  `RA_ASSERT_IMPL(a_quot_fits, state_r == ra_pkg::B_DONE, dvd_r[DW-1:AV] == '0)
  `RA_ASSERT_IMPL(a_out_held, $fell(out_valid_r), $past(out_pop))

endmodule

### hdl/rolling_average.sv
// Channel   Ports                                   Request moves
// input     in_push / in_full, in_sample            one 16-bit sample
// result    out_pop / out_empty, out_average, ...   mean (8 fraction bits) and count
// config    cfg_write, cfg_window_size              window size, empties the window
//
// Front stage takes a sample at once while filling and the queue has room; once full, each
// sample also passes the update state (store read) before the next is taken. Back stage
// divides at 2 quotient bits a cycle and sets the sustained rate; it pops a job when idle.
// A two-entry queue between the stages and the result register let each side stall alone.
// Synchronous active-low reset; window size returns to 8 and the window is empty.
module rolling_average #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_write,
  input  logic [ra_pkg::CNT_W-1:0]           cfg_window_size,
  input  logic                               in_push,
  input  logic signed [ra_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               in_full,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic signed [ra_pkg::AVG_W-1:0]    out_average,
  output logic [ra_pkg::CNT_W-1:0]           out_samples_held
);

  logic         q_push, q_full, q_pop, q_empty;
  ra_pkg::job_t q_job_in, q_job_out;

  ra_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write       (cfg_write),
    .cfg_window_size (cfg_window_size),
    .in_push         (in_push),
    .in_sample       (in_sample),
    .in_full         (in_full),
    .q_push          (q_push),
    .q_job           (q_job_in),
    .q_full          (q_full)
  );

  ra_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (q_job_in),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (q_job_out),
    .empty   (q_empty)
  );

  ra_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_job            (q_job_out),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_average      (out_average),
    .out_samples_held (out_samples_held)
  );

endmodule

### tb/sv/rolling_average_checker.sv
`timescale 1ns / 100ps

module rolling_average_checker #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write,
  input  logic [ra_pkg::CNT_W-1:0]            cfg_window_size,
  input  logic                                in_push,
  input  logic                                in_full,
  input  logic signed [ra_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                out_pop,
  input  logic                                out_empty,
  input  logic signed [ra_pkg::AVG_W-1:0]     out_average,
  input  logic [ra_pkg::CNT_W-1:0]            out_samples_held,
  output int                                  mismatches,
  output int                                  results_due
);

  typedef struct packed {
    logic signed [ra_pkg::AVG_W-1:0] average;
    logic [ra_pkg::CNT_W-1:0]        held;
  } mean_t;

  logic signed [ra_pkg::SAMPLE_W-1:0] window_q [MAX_WINDOW];
  logic signed [ra_pkg::SUM_W-1:0]    window_sum;
  int unsigned                        oldest;
  int unsigned                        held;
  int unsigned                        size_setting;
  mean_t                              expected_means [$];
  mean_t                              due_mean;

  function automatic int unsigned window_limit();
    if (size_setting == 0) return 1;
    if (size_setting > MAX_WINDOW) return MAX_WINDOW;
    return size_setting;
  endfunction

  // append while filling, replace the oldest entry once full
  function automatic mean_t advance_window(logic signed [ra_pkg::SAMPLE_W-1:0] s);
    int unsigned lim;
    int unsigned p;
    longint      scaled;
    mean_t       r;
    lim = window_limit();
    if (held < lim) begin
      window_q[held] = s;
      window_sum = window_sum + s;
      held++;
    end else begin
      p = oldest % lim;
      window_sum = window_sum - window_q[p] + s;
      window_q[p] = s;
      oldest = (p + 1) % lim;
    end
    scaled = longint'(window_sum) * 256;
    r.average = ra_pkg::AVG_W'(scaled / longint'(held));
    r.held = held[ra_pkg::CNT_W-1:0];
    return r;
  endfunction

  // queue the expected mean behind those still outstanding
  function automatic void store_mean(mean_t m);
    expected_means.insert(expected_means.size(), m);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      size_setting = ra_pkg::WINDOW_RESET;
      oldest = 0;
      held = 0;
      window_sum = '0;
      expected_means.delete();
    end else begin
      if (cfg_write) begin
        size_setting = cfg_window_size;
        oldest = 0;
        held = 0;
        window_sum = '0;
      end
      if (in_push && !in_full) store_mean(advance_window(in_sample));
      if (out_pop && !out_empty) begin
        if (expected_means.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request outstanding: average %0d held %0d",
                     $time, out_average, out_samples_held);
        end else begin
          due_mean = expected_means.pop_front();
          if (out_average !== due_mean.average || out_samples_held !== due_mean.held) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: average %0d held %0d, expected average %0d held %0d",
                       $time, out_average, out_samples_held, due_mean.average,
                       due_mean.held);
          end
        end
      end
    end
    results_due = expected_means.size();
  end

endmodule

### tb/sv/rolling_average_tb.sv
`timescale 1ns / 100ps

module rolling_average_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum int {
    MIX_UNIFORM,
    MIX_EXTREME,
    MIX_SMALL
  } sample_mix_t;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_write;
  logic [ra_pkg::CNT_W-1:0]           cfg_window_size;
  logic                               in_push;
  logic signed [ra_pkg::SAMPLE_W-1:0] in_sample;
  logic                               in_full;
  logic                               out_pop;
  logic                               out_empty;
  logic signed [ra_pkg::AVG_W-1:0]    out_average;
  logic [ra_pkg::CNT_W-1:0]           out_samples_held;

  int mismatches;
  int results_due;
  int stalled_cycles;
  bit calm;
  bit hold_off_req;

  rolling_average u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write        (cfg_write),
    .cfg_window_size  (cfg_window_size),
    .in_push          (in_push),
    .in_sample        (in_sample),
    .in_full          (in_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_average      (out_average),
    .out_samples_held (out_samples_held)
  );

  rolling_average_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write        (cfg_write),
    .cfg_window_size  (cfg_window_size),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample        (in_sample),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_average      (out_average),
    .out_samples_held (out_samples_held),
    .mismatches       (mismatches),
    .results_due      (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // called at a falling edge; returns at the falling edge after acceptance with push held
  task automatic push_item(input logic signed [ra_pkg::SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 33) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // write only once every outstanding request has been answered
  task automatic write_window(input logic [ra_pkg::CNT_W-1:0] size);
    drain_results();
    cfg_write <= 1'b1;
    cfg_window_size <= size;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [ra_pkg::SAMPLE_W-1:0] pick_sample(sample_mix_t mix,
                                                                     int idx);
    bit low_run;
    low_run = ((idx / 80) % 2) == 0;
    case (mix)
      MIX_EXTREME: begin
        if ($urandom_range(7) == 0) return low_run ? 16'sh7fff : 16'sh8000;
        return low_run ? 16'sh8000 : 16'sh7fff;
      end
      MIX_SMALL: return ra_pkg::SAMPLE_W'($signed($urandom_range(16)) - 8);
      default: return ra_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int          phase_size [8];
    sample_mix_t phase_mix [8];
    int          phase_items [8];
    rst_n = 1'b0;
    cfg_write = 1'b0;
    cfg_window_size = '0;
    in_push = 1'b0;
    in_sample = '0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default size of eight: fill past the edge with extremes
    push_item(16'sh7fff);
    push_item(16'sh7fff);
    push_item(16'sh7fff);
    push_item(16'sh8000);
    push_item(16'sh8000);
    push_item(16'sh8000);
    push_item(16'sh0001);
    push_item(16'shffff);
    push_item(16'sh5555);
    push_item(16'shaaaa);
    // same size again still empties the window
    write_window(7'd8);
    push_item(16'shffff);
    push_item(16'sh0000);
    push_item(16'sh0003);
    // zero behaves as one
    write_window(7'd0);
    push_item(16'sh8000);
    push_item(16'sh7fff);
    push_item(16'shfffd);
    write_window(7'd1);
    push_item(16'sh7fff);
    push_item(16'sh8000);
    // oversized clamps to the largest window
    write_window(7'd127);
    push_item(16'sh8000);
    push_item(16'sh7fff);

    phase_size = '{64, 127, 1, 0, 65, $urandom_range(63, 2), $urandom_range(127),
                   $urandom_range(16, 2)};
    phase_mix = '{MIX_EXTREME, MIX_UNIFORM, MIX_UNIFORM, MIX_SMALL, MIX_UNIFORM,
                  MIX_UNIFORM, MIX_EXTREME, MIX_SMALL};
    phase_items = '{140, 140, 90, 90, 140, 120, 120, 110};

    for (int ph = 0; ph < 8; ph++) begin
      write_window(ra_pkg::CNT_W'(phase_size[ph]));
      calm = (ph == 3);
      // hold the receiver off so the queue backs up into the input
      if (ph == 1) hold_off_req = 1'b1;
      for (int i = 0; i < phase_items[ph]; i++) push_item(pick_sample(phase_mix[ph], i));
    end
    calm = 1'b0;

    drain_results();
    repeat (30) @(negedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (calm) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= ($urandom_range(99) >= 33);
      end
    end
  end

  // count cycles without any request moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
